[src/bpfa_pkg.sv]
// Shared types and constants of the bitmap page frame allocator.
package bpfa_pkg;

    localparam int CNT_W   = 13;
    localparam int PAGE_W  = 12;
    localparam int ACT_W   = 3;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 56;

    localparam logic [CNT_W-1:0] CNT_MAX     = '1;
    localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(4096);

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC     = 3'd0,
        ACT_LOCK      = 3'd1,
        ACT_FREE      = 3'd2,
        ACT_RESERVE   = 3'd3,
        ACT_UNRESERVE = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_QUOT,
        ST_READ,
        ST_SCAN,
        ST_MODIFY,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic start;
        logic decode;
        logic read;
        logic scan;
        logic modify;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic is_alloc;
        logic clr_last;
        logic hit;
        logic more;
    } t_stat;

endpackage

[src/bpfa_ctrl.sv]
// Controller state machine of the bitmap page frame allocator.
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    input  logic  i_m_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE:   if (i_s_tvalid) n_state = ST_DIV;
            ST_DIV:    n_state = i_stat.bad ? ST_DONE : ST_QUOT;
            ST_QUOT:   n_state = ST_READ;
            ST_READ:   n_state = i_stat.is_alloc ? ST_SCAN : ST_MODIFY;
            ST_SCAN:   if (i_stat.hit || !i_stat.more) n_state = ST_DONE;
            ST_MODIFY: n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_CLEAR:  o_cmd.clr_step = 1'b1;
            ST_IDLE:   o_cmd.accept   = i_s_tvalid;
            ST_DIV:    o_cmd.start    = 1'b1;
            ST_QUOT:   o_cmd.decode   = 1'b1;
            ST_READ:   o_cmd.read     = 1'b1;
            ST_SCAN:   o_cmd.scan     = 1'b1;
            ST_MODIFY: o_cmd.modify   = 1'b1;
            ST_DONE:   o_cmd.load_out = out_free;
            default:   o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[src/bpfa_datapath.sv]
// Datapath of the bitmap page frame allocator: bitmap memory, counters, search.
module bpfa_datapath
    import bpfa_pkg::*;
#(
    parameter int NUM_PAGES = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic [IN_W-1:0]  i_s_tdata,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic [OUT_W-1:0] o_m_tdata
);

    // Pages at or above 2**CNT_W can never fall below the limit.
    localparam int EFF_PAGES = (NUM_PAGES < 2**CNT_W) ? NUM_PAGES : 2**CNT_W;
    localparam int IDX_W     = $clog2(EFF_PAGES);
    localparam int NUM_WORDS = (EFF_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int BASE_W    = CNT_W + 1;
    // Page / WORD_BITS as a multiply by a rounded-up reciprocal, exact below 2**CNT_W.
    localparam int SHIFT     = CNT_W + 6;
    localparam int RECIP     = (2**SHIFT + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = CNT_W + RECIP_W;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    logic [CNT_W-1:0]     r_total;
    logic [ACT_W-1:0]     r_action;
    logic [PAGE_W-1:0]    r_page;
    logic [PROD_W-1:0]    r_prod;
    logic [WA_W-1:0]      r_word;
    logic [BIT_W-1:0]     r_bit;
    logic [BASE_W-1:0]    r_base;
    logic                 r_first;
    logic [WORD_BITS-1:0] r_rd_data;
    logic [IDX_W-1:0]     r_hint;
    logic [CNT_W-1:0]     r_used;
    logic [CNT_W-1:0]     r_rsvd;
    logic                 r_ok;
    logic [PAGE_W-1:0]    r_given;
    logic [OUT_W-1:0]     r_out_data;

    logic [CNT_W-1:0]     limit;
    logic                 is_alloc;
    logic                 is_set_op;
    logic [CNT_W-1:0]     src;
    logic [PROD_W-1:0]    quot_full;
    logic [BASE_W-1:0]    quot_base;
    logic [WA_W-1:0]      rd_addr;
    logic                 rd_en;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic [BASE_W-1:0]    span;
    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] start_mask;
    logic [WORD_BITS-1:0] cand;
    logic [BIT_W-1:0]     find_idx;
    logic [BASE_W-1:0]    found_page;
    logic                 scan_hit;
    logic                 cur_bit;
    logic                 mod_change;
    logic [WORD_BITS-1:0] bit_mask;
    logic [CNT_W:0]       sum;
    logic [CNT_W-1:0]     free_pages;

    function automatic logic [BIT_W-1:0] f_lowest(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [CNT_W-1:0] f_up(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] f_down(input logic [CNT_W-1:0] c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

    assign limit = ({1'b0, r_total} < (CNT_W + 1)'(EFF_PAGES)) ? r_total
                                                              : CNT_W'(EFF_PAGES);
    assign is_alloc  = (r_action == ACT_ALLOC);
    assign is_set_op = (r_action == ACT_LOCK) || (r_action == ACT_RESERVE);
    assign src       = is_alloc ? CNT_W'(r_hint) : CNT_W'(r_page);

    assign quot_full = r_prod >> SHIFT;
    assign quot_base = BASE_W'(quot_full) * BASE_W'(WORD_BITS);

    // Search window of the current word
    assign span = BASE_W'(limit) - r_base;
    always_comb begin
        if (r_base >= BASE_W'(limit)) begin
            lim_mask = '0;
        end else if (span >= BASE_W'(WORD_BITS)) begin
            lim_mask = '1;
        end else begin
            lim_mask = ~({WORD_BITS{1'b1}} << span[BIT_W-1:0]);
        end
    end
    assign start_mask = r_first ? ({WORD_BITS{1'b1}} << r_bit) : '1;
    assign cand       = ~r_rd_data & lim_mask & start_mask;
    assign scan_hit   = |cand;
    assign find_idx   = f_lowest(cand);
    assign found_page = r_base + BASE_W'(find_idx);

    assign bit_mask   = WORD_BITS'(1) << r_bit;
    assign cur_bit    = r_rd_data[r_bit];
    assign mod_change = is_set_op ? !cur_bit : cur_bit;

    assign o_stat.bad      = (r_action > ACT_UNRESERVE) ||
                             (!is_alloc && ({1'b0, r_page} >= limit));
    assign o_stat.is_alloc = is_alloc;
    assign o_stat.clr_last = (r_word == WA_W'(NUM_WORDS - 1));
    assign o_stat.hit      = scan_hit;
    assign o_stat.more     = (r_base + BASE_W'(WORD_BITS)) < BASE_W'(limit);

    // Memory port control
    always_comb begin
        rd_en   = i_cmd.read || i_cmd.scan;
        rd_addr = i_cmd.scan ? r_word + 1'b1 : r_word;
        wr_en   = 1'b0;
        wr_data = '0;
        if (i_cmd.clr_step) begin
            wr_en = 1'b1;
        end else if (i_cmd.scan && scan_hit) begin
            wr_en   = 1'b1;
            wr_data = r_rd_data | (WORD_BITS'(1) << find_idx);
        end else if (i_cmd.modify && mod_change) begin
            wr_en   = 1'b1;
            wr_data = is_set_op ? (r_rd_data | bit_mask) : (r_rd_data & ~bit_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_word] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign sum        = (CNT_W + 1)'(r_used) + (CNT_W + 1)'(r_rsvd);
    assign free_pages = ({1'b0, limit} > sum) ? CNT_W'({1'b0, limit} - sum) : '0;

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_s_tdata[ACT_W-1:0];
            r_page   <= i_s_tdata[ACT_W+PAGE_W-1:ACT_W];
            r_ok     <= 1'b0;
            r_given  <= '0;
        end
        if (i_cmd.start) begin
            r_prod <= PROD_W'(src) * PROD_W'(RECIP);
        end
        if (i_cmd.decode) begin
            r_base  <= quot_base;
            r_bit   <= BIT_W'(src - CNT_W'(quot_base));
            r_first <= 1'b1;
        end
        if (i_cmd.scan) begin
            if (scan_hit) begin
                r_ok    <= 1'b1;
                r_given <= PAGE_W'(found_page);
            end else begin
                r_base  <= r_base + BASE_W'(WORD_BITS);
                r_first <= 1'b0;
            end
        end
        if (i_cmd.modify && mod_change) begin
            r_ok <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_data <= {4'b0, r_rsvd, r_used, free_pages, r_given, r_ok};
        end
    end

    // Control state: config, word pointer, hint and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RESET;
            r_word  <= '0;
            r_hint  <= '0;
            r_used  <= '0;
            r_rsvd  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_total <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_word <= r_word + 1'b1;
            end else if (i_cmd.decode) begin
                r_word <= WA_W'(quot_full);
            end else if (i_cmd.scan && !scan_hit) begin
                r_word <= r_word + 1'b1;
            end
            if (i_cmd.scan && scan_hit) begin
                r_hint <= IDX_W'(found_page);
                r_used <= f_up(r_used);
            end
            if (i_cmd.modify && mod_change) begin
                priority case (r_action)
                    ACT_LOCK:    r_used <= f_up(r_used);
                    ACT_RESERVE: r_rsvd <= f_up(r_rsvd);
                    ACT_FREE:    r_used <= f_down(r_used);
                    default:     r_rsvd <= f_down(r_rsvd);
                endcase
                if (!is_set_op && (CNT_W'(r_page) < CNT_W'(r_hint))) begin
                    r_hint <= IDX_W'(r_page);
                end
            end
        end
    end

    assign o_m_tdata = r_out_data;

endmodule

[src/bitmap_page_frame_allocator_unit.sv]
// Top level of the bitmap page frame allocator.
// Usage:
//   Slave stream (i_s_*) takes one request per handshake: action and page.
//   Master stream (o_m_*) returns exactly one result per request: ok,
//   alloc_page and the free, used and reserved page counts after the request.
//   The cfg channel writes total_pages; write it only while no request is
//   in flight. It is always ready.
// Timing:
//   Lock, free, reserve and unreserve pass through DIV, QUOT, READ,
//   MODIFY and DONE to the result register; allocate runs SCAN instead
//   of MODIFY, one bitmap word per cycle from the hint word up to the hit
//   or the last page. An unknown action or out-of-range page skips to DONE.
//   A new request can be taken in the cycle after the previous result loads.
// Reset:
//   Counts, hint and total_pages return to their defaults, then the bitmap
//   memory is swept to zero, one word per cycle (NUM_WORDS words, 64 at the
//   default size); o_s_tready stays low during the sweep.
// Stall:
//   A stalled result waits in the output register; the next request is
//   still accepted and held in its final state until the register frees up.
module bitmap_page_frame_allocator_unit
    import bpfa_pkg::*;
#(
    parameter int NUM_PAGES = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // action[2:0], page[14:3], zero pad
    // result channel
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // ok[0], alloc_page[12:1],
                                          // free_pages[25:13], used_pages[38:26],
                                          // reserved_pages[51:39], zero pad
    // configuration write channel
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data   // total_pages
);

    t_cmd  cmd;
    t_stat stat;

    // The user must issue config writes only while idle; the block does not enforce it and takes them at once.
    assign o_cfg_ready = 1'b1;

    bpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bpfa_datapath #(
        .NUM_PAGES (NUM_PAGES),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_m_tdata   (o_m_tdata)
    );

    // Drop ready for the request in flight right after it is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while a request was in flight");

    // A page number is only handed out with a successful result.
    a_page_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[12:1] != 12'd0)) |-> o_m_tdata[0])
        else $error("alloc_page nonzero on a failed result");

    // Hold off requests while the bitmap sweep runs after reset.
    a_sweep_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_s_tready)
        else $error("request port ready before the bitmap sweep");

    // The sweep always leaves the controller idle, never in a work state.
    a_sweep_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.clr_step && stat.clr_last) |=> (o_s_tready && !cmd.clr_step))
        else $error("bitmap sweep did not end in idle");

endmodule

[tb/sv/bitmap_page_frame_allocator_unit_tb.sv]
// Self-checking stream testbench of the bitmap page frame allocator with its own allocator model.
module bitmap_page_frame_allocator_unit_tb
    import bpfa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES        = 4096;
    localparam int WATCHDOG     = 4000;   // cycles with no handshake of any kind
    localparam int LONG_HOLD    = 500;    // one long receiver hold-off
    localparam int HOLD_AT      = 400;    // start it after this many results
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PAGE_W-1:0] page;
    } t_request;

    typedef struct packed {
        logic              ok;
        logic [PAGE_W-1:0] alloc_page;
        logic [CNT_W-1:0]  free_pages;
        logic [CNT_W-1:0]  used_pages;
        logic [CNT_W-1:0]  reserved_pages;
    } t_result;

    // DUT connections; every input starts at a known value
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata   = '0;   // action[2:0], page[14:3], zero pad
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [OUT_W-1:0]  o_m_tdata;          // ok[0], alloc_page[12:1], free_pages[25:13],
                                           // used_pages[38:26], reserved_pages[51:39]
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data  = '0;   // total_pages

    // allocator model state, mirrors the block after reset
    bit                busy_map [PAGES];
    logic [PAGE_W-1:0] free_hint     = '0;
    logic [CNT_W-1:0]  used_cnt      = '0;
    logic [CNT_W-1:0]  reserved_cnt  = '0;
    logic [CNT_W-1:0]  total_pages   = TOTAL_RESET;

    t_request request_queue [$];      // requests waiting to be offered
    t_result  predicted_results [$];  // results owed by the block, oldest first

    int  err_count     = 0;
    int  results_seen  = 0;
    int  idle_cycles   = 0;
    bit  tx_presenting = 1'b0;
    bit  tx_steady     = 1'b0;        // phase without sender gaps
    bit  rx_steady     = 1'b0;        // phase without receiver gaps

    bitmap_page_frame_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] count_down(logic [CNT_W-1:0] c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

    // Apply one request to the allocator model and return the result it owes.
    function automatic t_result allocator_step(t_request req);
        t_result          r;
        logic [CNT_W-1:0] lim;
        int               p;
        int               sum;
        r   = '0;
        lim = (total_pages < PAGES) ? total_pages : CNT_W'(PAGES);
        if (req.action == ACT_ALLOC) begin
            // search upward from the hint only, never below it
            for (p = 32'(free_hint); p < 32'(lim); p++) begin
                if (!busy_map[p]) begin
                    busy_map[p]  = 1'b1;
                    free_hint    = PAGE_W'(p);
                    used_cnt     = count_up(used_cnt);
                    r.ok         = 1'b1;
                    r.alloc_page = PAGE_W'(p);
                    break;
                end
            end
        end else if (req.action <= ACT_UNRESERVE && req.page < lim) begin
            if ((req.action == ACT_LOCK || req.action == ACT_RESERVE) && !busy_map[req.page]) begin
                busy_map[req.page] = 1'b1;
                if (req.action == ACT_LOCK) used_cnt = count_up(used_cnt);
                else reserved_cnt = count_up(reserved_cnt);
                r.ok = 1'b1;
            end else if ((req.action == ACT_FREE || req.action == ACT_UNRESERVE)
                         && busy_map[req.page]) begin
                busy_map[req.page] = 1'b0;
                if (req.action == ACT_FREE) used_cnt = count_down(used_cnt);
                else reserved_cnt = count_down(reserved_cnt);
                if (req.page < free_hint) free_hint = req.page;
                r.ok = 1'b1;
            end
        end
        sum              = 32'(used_cnt) + 32'(reserved_cnt);
        r.free_pages     = (32'(lim) > sum) ? CNT_W'(32'(lim) - sum) : '0;
        r.used_pages     = used_cnt;
        r.reserved_pages = reserved_cnt;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $time, what);
        err_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic push_request(logic [ACT_W-1:0] act, logic [PAGE_W-1:0] pg);
        t_request req;
        req.action = act;
        req.page   = pg;
        request_queue.push_back(req);
    endtask

    // Pick a page mostly near the managed range, sometimes anywhere.
    function automatic logic [PAGE_W-1:0] pick_page(int lim);
        int span;
        span = lim + lim / 8 + 2;
        if (span > PAGES) span = PAGES;
        if ($urandom_range(0, 99) < 85) return PAGE_W'($urandom_range(0, span - 1));
        return PAGE_W'($urandom_range(0, PAGES - 1));
    endfunction

    // Queue a random mix: allocate runs, frees and unreserves that often hit
    // busy pages, locks and reserves, a little noise of unknown actions.
    task automatic queue_random_mix(int count, int lim);
        int n;
        int r;
        int k;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                for (k = $urandom_range(2, 10); k > 0; k--) begin
                    push_request(ACT_ALLOC, PAGE_W'($urandom));
                    n++;
                end
            end else begin
                if      (r < 40) push_request(ACT_ALLOC, PAGE_W'($urandom));
                else if (r < 52) push_request(ACT_LOCK, pick_page(lim));
                else if (r < 72) push_request(ACT_FREE, pick_page(lim));
                else if (r < 84) push_request(ACT_RESERVE, pick_page(lim));
                else if (r < 97) push_request(ACT_UNRESERVE, pick_page(lim));
                else push_request(ACT_W'($urandom_range(5, 7)), PAGE_W'($urandom));
                n++;
            end
        end
    endtask

    // Hold until every queued request has been taken and every result has come back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_queue.size() != 0 || tx_presenting || predicted_results.size() != 0);
    endtask

    // Write total_pages while the block is idle and track it in the model.
    task automatic write_total_pages(logic [CNT_W-1:0] value);
        wait_drained();
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        total_pages = value;
    endtask

    // Request driver: predict on every accepted request, then offer the next
    // one after a random gap. tvalid gets exactly one assignment per edge.
    always @(posedge i_clk) begin
        int       tx_gap;
        t_request cur;
        if (!i_rst_n) begin
            i_s_tvalid    <= 1'b0;
            tx_presenting = 1'b0;
            tx_gap        = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                cur.action = i_s_tdata[2:0];
                cur.page   = i_s_tdata[14:3];
                predicted_results.push_back(allocator_step(cur));
                tx_presenting = 1'b0;
                tx_gap        = tx_steady ? 0 : gap_len();
            end
            if (!tx_presenting) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (request_queue.size() != 0) begin
                    cur = request_queue.pop_front();
                    i_s_tdata     <= {1'b0, cur.page, cur.action};
                    tx_presenting = 1'b1;
                end
            end
            i_s_tvalid <= tx_presenting;
        end
    end

    // Result ready: random gaps, plus one long hold-off counted here so that
    // the block fills up and stalls its request side.
    always @(posedge i_clk) begin
        int rx_gap;
        int hold_left;
        bit hold_done;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_gap    = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) rx_gap = rx_steady ? 0 : gap_len();
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (predicted_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = predicted_results.pop_front();
                compare_field("ok", 32'(o_m_tdata[0]), 32'(want.ok));
                compare_field("alloc_page", 32'(o_m_tdata[12:1]), 32'(want.alloc_page));
                compare_field("free_pages", 32'(o_m_tdata[25:13]), 32'(want.free_pages));
                compare_field("used_pages", 32'(o_m_tdata[38:26]), 32'(want.used_pages));
                compare_field("reserved_pages", 32'(o_m_tdata[51:39]),
                              32'(want.reserved_pages));
            end
        end
    end

    // Watchdog: abort when no handshake of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("bitmap_page_frame_allocator_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [CNT_W-1:0] phase_total [9];
        int               ph;
        int               lim;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset page count.
        push_request(ACT_ALLOC, '0);          // first page
        push_request(ACT_ALLOC, '1);          // page field ignored on allocate
        push_request(ACT_LOCK, '1);           // top page
        push_request(ACT_LOCK, '1);           // already busy
        push_request(ACT_RESERVE, 12'd2);
        push_request(ACT_ALLOC, '0);          // skips the reserved page
        push_request(ACT_FREE, 12'd1);        // lowers the hint
        push_request(ACT_ALLOC, '0);          // reuses the freed page
        push_request(ACT_UNRESERVE, 12'd2);
        push_request(ACT_UNRESERVE, 12'd2);   // already clear
        push_request(ACT_FREE, 12'd0);
        push_request(ACT_LOCK, 12'd5);
        push_request(ACT_UNRESERVE, 12'd5);   // reserved count stays at zero
        push_request(ACT_FREE, 12'd5);        // already clear
        push_request(ACT_W'(5), '1);          // unknown actions
        push_request(ACT_W'(6), 12'hAAA);
        push_request(ACT_W'(7), 12'h555);
        push_request(ACT_LOCK, 12'hAAA);
        push_request(ACT_FREE, 12'hAAA);
        push_request(ACT_RESERVE, 12'h555);
        push_request(ACT_UNRESERVE, 12'h555);

        // Zero limit: every action fails.
        write_total_pages('0);
        push_request(ACT_ALLOC, '0);
        push_request(ACT_LOCK, '0);
        push_request(ACT_FREE, 12'd3);

        // One page: allocate it, then nothing is left and page 1 is out of range.
        write_total_pages(13'd1);
        push_request(ACT_ALLOC, '0);
        push_request(ACT_ALLOC, '0);
        push_request(ACT_LOCK, 12'd1);

        // Random phases over several limits, small ones so the map fills.
        phase_total[0] = 13'd64;
        phase_total[1] = 13'd200;
        phase_total[2] = 13'd1;
        phase_total[3] = 13'd130;
        phase_total[4] = 13'd0;
        phase_total[5] = CNT_MAX;             // above the page count
        phase_total[6] = 13'd4096;
        phase_total[7] = CNT_W'($urandom_range(2, 300));
        phase_total[8] = CNT_W'($urandom_range(1000, 4095));

        for (ph = 0; ph < 9; ph++) begin
            write_total_pages(phase_total[ph]);
            tx_steady = (ph % 3 == 1);
            rx_steady = (ph % 3 == 1);
            lim = (32'(phase_total[ph]) < PAGES) ? 32'(phase_total[ph]) : PAGES;
            queue_random_mix(140, lim);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_results.size() != 0)
            report_mismatch("results still outstanding at end of run");

        if (err_count == 0) begin
            $display("bitmap_page_frame_allocator_unit verification clean");
        end else begin
            $display("bitmap_page_frame_allocator_unit verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/bpfa_pkg.sv
src/bpfa_ctrl.sv
src/bpfa_datapath.sv
src/bitmap_page_frame_allocator_unit.sv
tb/sv/bitmap_page_frame_allocator_unit_tb.sv
